// File: sv/console_line_editor_defines.svh
// ----------------------------------------------------------------------------
// Console line editor: assertion macros
// Shared helpers for concurrent checks on the line editor ports.
// ----------------------------------------------------------------------------
`ifndef CONSOLE_LINE_EDITOR_DEFINES_SVH
`define CONSOLE_LINE_EDITOR_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CLE_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("line editor check failed");

// Consequent must hold in the cycle after the antecedent.
`define CLE_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("line editor check failed");

`endif

// File: sv/cle_pkg.sv
// ----------------------------------------------------------------------------
// Console line editor package
// Key codes, operation codes, system action codes and controller states.
// ----------------------------------------------------------------------------
package cle_pkg;

    localparam logic OP_KEY  = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [7:0] KEY_NUL = 8'h00;
    localparam logic [7:0] KEY_CR  = 8'h0D;
    localparam logic [7:0] KEY_NL  = 8'h0A;
    localparam logic [7:0] KEY_DEL = 8'h7F;
    localparam logic [7:0] CTRL_D  = 8'h04;
    localparam logic [7:0] CTRL_U  = 8'h15;
    localparam logic [7:0] CTRL_H  = 8'h08;
    localparam logic [7:0] CTRL_Z  = 8'h1A;
    localparam logic [7:0] CTRL_Q  = 8'h11;
    localparam logic [7:0] CTRL_P  = 8'h10;

    localparam logic [7:0] ERASE_MAX = 8'd255;

    typedef enum logic [1:0] {
        SYS_NONE   = 2'd0,
        SYS_REBOOT = 2'd1,
        SYS_HALT   = 2'd2,
        SYS_PLIST  = 2'd3
    } cle_sys_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_READ = 1'b1
    } cle_state_t;

endpackage

// File: sv/console_line_editor.sv
// ----------------------------------------------------------------------------
// Console line editor
// Canonical-mode keyboard line buffer on a ring of BUFFER_DEPTH bytes.
// ----------------------------------------------------------------------------
// A key item (op 0) gives its result in the cycle after the transfer, and the
// block takes the next item in that same cycle. A read item (op 1) on an
// empty buffer also answers in the cycle after; otherwise the byte comes
// from the single ring store, whose read data is registered, so the block
// waits in its read state with busy high. Each result shows on the result
// ports for one cycle with done high; the receiver cannot stall it. Indices
// run modulo twice the depth; the store needs no clearing after reset.
// ----------------------------------------------------------------------------
module console_line_editor
    import cle_pkg::*;
#(
    parameter int BUFFER_DEPTH = 128
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic       op,
    input  logic [7:0] key,
    input  logic       continuing_read,
    output logic       done,
    output logic       echo_valid,
    output logic [7:0] echo_char,
    output logic [7:0] erase_count,
    output logic       line_ready,
    output logic [1:0] system_action,
    output logic       read_valid,
    output logic [7:0] read_char,
    output logic       read_eof,
    output logic       read_empty
);

    localparam int IW = $clog2(2 * BUFFER_DEPTH);
    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam logic [IW-1:0] IDX_LAST = IW'(2 * BUFFER_DEPTH - 1);
    localparam logic [IW-1:0] IDX_SPAN = IW'(2 * BUFFER_DEPTH);
    localparam logic [IW-1:0] DEPTH_I  = IW'(BUFFER_DEPTH);

    function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] i);
        return (i == IDX_LAST) ? '0 : i + IW'(1);
    endfunction

    function automatic logic [IW-1:0] idx_dec(input logic [IW-1:0] i);
        return (i == '0) ? IDX_LAST : i - IW'(1);
    endfunction

    function automatic logic [IW-1:0] idx_dist(input logic [IW-1:0] hi,
                                               input logic [IW-1:0] lo);
        logic [IW-1:0] d;
        d = hi - lo;
        if (hi < lo)
        begin
            d = d + IDX_SPAN;
        end
        return d;
    endfunction

    function automatic logic [AW-1:0] idx_addr(input logic [IW-1:0] i);
        logic [IW-1:0] a;
        a = (i >= DEPTH_I) ? i - DEPTH_I : i;
        return a[AW-1:0];
    endfunction

    cle_state_t    state_reg, state_next;
    logic [IW-1:0] read_idx_reg, read_idx_next;
    logic [IW-1:0] commit_idx_reg, commit_idx_next;
    logic [IW-1:0] edit_idx_reg, edit_idx_next;
    logic          cont_reg, cont_next;

    logic          done_reg, done_next;
    logic          echo_valid_reg, echo_valid_next;
    logic [7:0]    echo_char_reg, echo_char_next;
    logic [7:0]    erase_count_reg, erase_count_next;
    logic          line_ready_reg, line_ready_next;
    cle_sys_t      sys_reg, sys_next;
    logic          read_valid_reg, read_valid_next;
    logic [7:0]    read_char_reg, read_char_next;
    logic          read_eof_reg, read_eof_next;
    logic          read_empty_reg, read_empty_next;

    logic          take;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic          rd_en;
    logic [7:0]    rd_data;
    logic [IW-1:0] edit_inc;
    logic [IW-1:0] kill_dist;
    logic [7:0]    store_char;

    cle_line_ram #(
        .DEPTH (BUFFER_DEPTH),
        .AW    (AW)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (idx_addr(read_idx_reg)),
        .rd_data (rd_data)
    );

    assign take       = start && (state_reg == ST_IDLE);
    assign edit_inc   = idx_inc(edit_idx_reg);
    assign kill_dist  = idx_dist(edit_idx_reg, commit_idx_reg);
    assign store_char = (key == KEY_CR) ? KEY_NL : key;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (take && op == OP_READ && read_idx_reg != commit_idx_reg)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        busy             = (state_reg == ST_READ);
        rd_en            = 1'b0;
        wr_en            = 1'b0;
        wr_addr          = idx_addr(edit_idx_reg);
        wr_data          = store_char;
        read_idx_next    = read_idx_reg;
        commit_idx_next  = commit_idx_reg;
        edit_idx_next    = edit_idx_reg;
        cont_next        = cont_reg;
        done_next        = 1'b0;
        echo_valid_next  = 1'b0;
        echo_char_next   = '0;
        erase_count_next = '0;
        line_ready_next  = 1'b0;
        sys_next         = SYS_NONE;
        read_valid_next  = 1'b0;
        read_char_next   = '0;
        read_eof_next    = 1'b0;
        read_empty_next  = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (take && op == OP_KEY)
                begin
                    done_next = 1'b1;
                    case (key)
                        CTRL_Z: sys_next = SYS_REBOOT;
                        CTRL_Q: sys_next = SYS_HALT;
                        CTRL_P: sys_next = SYS_PLIST;
                        CTRL_U:
                        begin
                            erase_count_next = (32'(kill_dist) > 32'(ERASE_MAX))
                                             ? ERASE_MAX : 8'(kill_dist);
                            edit_idx_next    = commit_idx_reg;
                        end
                        CTRL_H, KEY_DEL:
                        begin
                            if (edit_idx_reg != commit_idx_reg)
                            begin
                                edit_idx_next    = idx_dec(edit_idx_reg);
                                erase_count_next = 8'd1;
                            end
                        end
                        default:
                        begin
                            // store only when the ring has room; drop otherwise
                            if (key != KEY_NUL &&
                                idx_dist(edit_idx_reg, read_idx_reg) < DEPTH_I)
                            begin
                                wr_en           = 1'b1;
                                edit_idx_next   = edit_inc;
                                echo_valid_next = 1'b1;
                                echo_char_next  = store_char;
                                if (store_char == KEY_NL || store_char == CTRL_D ||
                                    idx_dist(edit_inc, read_idx_reg) == DEPTH_I)
                                begin
                                    commit_idx_next = edit_inc;
                                    line_ready_next = 1'b1;
                                end
                            end
                        end
                    endcase
                end
                else if (take)
                begin
                    if (read_idx_reg == commit_idx_reg)
                    begin
                        done_next       = 1'b1;
                        read_empty_next = 1'b1;
                    end
                    else
                    begin
                        rd_en     = 1'b1;
                        cont_next = continuing_read;
                    end
                end
            end
            ST_READ:
            begin
                done_next = 1'b1;
                if (rd_data == CTRL_D)
                begin
                    // leave the end-of-file mark in place mid-read
                    read_eof_next = 1'b1;
                    if (!cont_reg)
                    begin
                        read_idx_next = idx_inc(read_idx_reg);
                    end
                end
                else
                begin
                    read_valid_next = 1'b1;
                    read_char_next  = rd_data;
                    read_idx_next   = idx_inc(read_idx_reg);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            read_idx_reg    <= '0;
            commit_idx_reg  <= '0;
            edit_idx_reg    <= '0;
            cont_reg        <= 1'b0;
            done_reg        <= 1'b0;
            echo_valid_reg  <= 1'b0;
            echo_char_reg   <= '0;
            erase_count_reg <= '0;
            line_ready_reg  <= 1'b0;
            sys_reg         <= SYS_NONE;
            read_valid_reg  <= 1'b0;
            read_char_reg   <= '0;
            read_eof_reg    <= 1'b0;
            read_empty_reg  <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            read_idx_reg    <= read_idx_next;
            commit_idx_reg  <= commit_idx_next;
            edit_idx_reg    <= edit_idx_next;
            cont_reg        <= cont_next;
            done_reg        <= done_next;
            echo_valid_reg  <= echo_valid_next;
            echo_char_reg   <= echo_char_next;
            erase_count_reg <= erase_count_next;
            line_ready_reg  <= line_ready_next;
            sys_reg         <= sys_next;
            read_valid_reg  <= read_valid_next;
            read_char_reg   <= read_char_next;
            read_eof_reg    <= read_eof_next;
            read_empty_reg  <= read_empty_next;
        end
    end

    assign done          = done_reg;
    assign echo_valid    = echo_valid_reg;
    assign echo_char     = echo_char_reg;
    assign erase_count   = erase_count_reg;
    assign line_ready    = line_ready_reg;
    assign system_action = sys_reg;
    assign read_valid    = read_valid_reg;
    assign read_char     = read_char_reg;
    assign read_eof      = read_eof_reg;
    assign read_empty    = read_empty_reg;

endmodule

// File: sv/cle_line_ram.sv
// ----------------------------------------------------------------------------
// Console line editor ring store
// One write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module cle_line_ram #(
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: sv/cle_checker.sv
// ----------------------------------------------------------------------------
// Console line editor checker
// Port-level checks on result timing and result field consistency.
// ----------------------------------------------------------------------------
`include "console_line_editor_defines.svh"

module cle_checker
    import cle_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       op,
    input logic       done,
    input logic       echo_valid,
    input logic [7:0] echo_char,
    input logic [7:0] erase_count,
    input logic       line_ready,
    input logic [1:0] system_action,
    input logic       read_valid,
    input logic       read_eof,
    input logic       read_empty
);

    // a key transfer always answers in the next cycle
    `CLE_ASSERT_NEXT(a_key_done, clk, rst_n, start && !busy && op == OP_KEY, done && !busy)

    // a read transfer either answers next cycle or waits on the store
    `CLE_ASSERT_NEXT(a_read_done, clk, rst_n, start && !busy && op == OP_READ, done != busy)

    // a committed line is always the echo of a stored terminator or last byte
    `CLE_ASSERT_NOW(a_commit_echo, clk, rst_n, line_ready, done && echo_valid && echo_char != KEY_CR && echo_char != KEY_NUL)

    // read outcomes are exclusive and never mix with key outcomes
    `CLE_ASSERT_NOW(a_read_excl, clk, rst_n, read_valid || read_eof || read_empty, done && $onehot({read_valid, read_eof, read_empty}) && !echo_valid && erase_count == 8'd0 && system_action == SYS_NONE)

endmodule

bind console_line_editor cle_checker u_cle_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .op            (op),
    .done          (done),
    .echo_valid    (echo_valid),
    .echo_char     (echo_char),
    .erase_count   (erase_count),
    .line_ready    (line_ready),
    .system_action (system_action),
    .read_valid    (read_valid),
    .read_eof      (read_eof),
    .read_empty    (read_empty)
);
